// ===== sv/hbsb_pkg.sv =====
// hbsb_pkg: shared widths, action codes, register indexes and duty scaling
// constants for the H-bridge surge blanking block.
// No dependencies.
package hbsb_pkg;

  // Field widths
  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned VOLT_W    = 14;
  localparam int unsigned CUR_W     = 12;
  localparam int unsigned TICK_W    = 8;
  localparam int unsigned DUTY_W    = 14;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 14;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_SET   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CHECK = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLANKING_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_LOW    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_HIGH   = 2'd3;

  // Configuration reset values
  localparam logic [TICK_W-1:0] BLANKING_TICKS_RST = 8'd2;
  localparam logic [VOLT_W-1:0] RISE_THRESHOLD_RST = 14'd500;
  localparam logic [CUR_W-1:0]  CURRENT_LOW_RST    = 12'd700;
  localparam logic [CUR_W-1:0]  CURRENT_HIGH_RST   = 12'd2400;

  // PWM scaling: duty = floor(mv * PWM_PERIOD / FULL_SCALE_MV), saturated
  localparam logic [DUTY_W-1:0] PWM_PERIOD    = 14'd12287;
  localparam longint unsigned   FULL_SCALE_MV = 64'd12000;

  // Reciprocal multiply. 2^28 exceeds max_mv * FULL_SCALE_MV, so the
  // rounded-up multiplier gives the exact floor for every 14-bit voltage.
  localparam int unsigned     DUTY_SHIFT  = 28;
  localparam int unsigned     DUTY_MULT_W = 29;
  localparam longint unsigned DUTY_MULT_L =
    ((longint'(PWM_PERIOD) << DUTY_SHIFT) + FULL_SCALE_MV - 64'd1) / FULL_SCALE_MV;
  localparam logic [DUTY_MULT_W-1:0] DUTY_MULT = DUTY_MULT_L[DUTY_MULT_W-1:0];

endpackage

// ===== sv/hbsb_if.sv =====
// hbsb_if: valid/ready channels for command words and result words.
// Depends on hbsb_pkg.
interface hbsb_cmd_if import hbsb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [VOLT_W-1:0]   voltage_mv;
  logic                direction;
  logic [CUR_W-1:0]    current_mv;

  modport source (output valid, action, voltage_mv, direction, current_mv, input ready);
  modport sink   (input valid, action, voltage_mv, direction, current_mv, output ready);
endinterface

interface hbsb_res_if import hbsb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] duty_a;
  logic [DUTY_W-1:0] duty_b;
  logic              low_a_on;
  logic              low_b_on;
  logic              current_ok;

  modport source (output valid, duty_a, duty_b, low_a_on, low_b_on, current_ok,
                  input ready);
  modport sink   (input valid, duty_a, duty_b, low_a_on, low_b_on, current_ok,
                  output ready);
endinterface

// ===== sv/hbsb_duty.sv =====
// hbsb_duty: scales a millivolt request to a PWM compare value with
// saturation at the PWM period. Depends on hbsb_pkg.
module hbsb_duty import hbsb_pkg::*; (
  input  logic [VOLT_W-1:0] voltage_mv,
  output logic [DUTY_W-1:0] duty
);

  localparam int unsigned PROD_W = VOLT_W + DUTY_MULT_W;
  localparam int unsigned QUOT_W = PROD_W - DUTY_SHIFT;

  logic [PROD_W-1:0] prod;
  logic [QUOT_W-1:0] quot;

  // Multiply by the reciprocal of full scale, keep the integer part
  assign prod = PROD_W'(voltage_mv) * PROD_W'(DUTY_MULT);
  assign quot = prod[PROD_W-1:DUTY_SHIFT];

  // Clamp above full scale
  assign duty = (quot > QUOT_W'(PWM_PERIOD)) ? PWM_PERIOD : quot[DUTY_W-1:0];

endmodule

// ===== sv/hbridge_drive_surge_blanking.sv =====
// hbridge_drive_surge_blanking: one H-bridge channel with surge blanking.
// The word lands in the input register at the accept edge and moves on to the
// result register when that register is free. Throughput: one word per cycle
// while results are taken, no bubbles. All the work for a word is one
// combinational pass (duty scaling multiply and compares) between the two registers.
// Reset (rst, synchronous): both stages empty, config at defaults, bridge
// held with both duties 0 and the side B low switch on.
module hbridge_drive_surge_blanking import hbsb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  hbsb_cmd_if.sink             cmd,
  hbsb_res_if.source           res,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_DAT_W-1:0] wr_data
);

  // Configuration
  logic [TICK_W-1:0] blanking_ticks;
  logic [VOLT_W-1:0] rise_threshold_mv;
  logic [CUR_W-1:0]  current_low_mv;
  logic [CUR_W-1:0]  current_high_mv;

  // Input stage
  logic                s0_valid;
  logic [ACTION_W-1:0] s0_action;
  logic [VOLT_W-1:0]   s0_voltage;
  logic                s0_direction;
  logic [CUR_W-1:0]    s0_current;

  // Channel state
  logic [VOLT_W-1:0] last_voltage, last_voltage_next;
  logic              blanking_active, blanking_active_next;
  logic [TICK_W-1:0] elapsed_ticks, elapsed_ticks_next;
  logic [DUTY_W-1:0] held_duty_a, held_duty_a_next;
  logic [DUTY_W-1:0] held_duty_b, held_duty_b_next;
  logic              held_low_a, held_low_a_next;
  logic              held_low_b, held_low_b_next;

  // Result stage
  logic out_valid;
  logic current_ok, current_ok_next;

  logic              advance;
  logic [DUTY_W-1:0] duty;
  logic [VOLT_W:0]   rise_limit;

  // Handshake: stage 0 moves on whenever the result register is free
  assign advance   = s0_valid && (!out_valid || res.ready);
  assign cmd.ready = !s0_valid || advance;

  hbsb_duty u_duty (
    .voltage_mv (s0_voltage),
    .duty       (duty)
  );

  assign rise_limit = {1'b0, last_voltage} + {1'b0, rise_threshold_mv};

  // Next state and verdict for the word in stage 0
  always_comb begin
    last_voltage_next    = last_voltage;
    blanking_active_next = blanking_active;
    elapsed_ticks_next   = elapsed_ticks;
    held_duty_a_next     = held_duty_a;
    held_duty_b_next     = held_duty_b;
    held_low_a_next      = held_low_a;
    held_low_b_next      = held_low_b;
    current_ok_next      = 1'b1;
    case (s0_action)
      ACT_SET: begin
        // a rise beyond the threshold restarts blanking
        if ({1'b0, s0_voltage} > rise_limit) begin
          blanking_active_next = 1'b1;
          elapsed_ticks_next   = '0;
        end
        if (!s0_direction) begin
          held_low_a_next  = 1'b0;
          held_low_b_next  = 1'b1;
          held_duty_a_next = duty;
          held_duty_b_next = '0;
        end else begin
          held_low_a_next  = 1'b1;
          held_low_b_next  = 1'b0;
          held_duty_a_next = '0;
          held_duty_b_next = duty;
        end
        last_voltage_next = s0_voltage;
      end
      ACT_TICK: begin
        if (elapsed_ticks != '1) begin
          elapsed_ticks_next = elapsed_ticks + TICK_W'(1);
        end
      end
      ACT_CHECK: begin
        // window expired: end blanking and test the sample
        if (blanking_active && (elapsed_ticks >= blanking_ticks)) begin
          blanking_active_next = 1'b0;
          if (!(s0_current inside {[current_low_mv:current_high_mv]})) begin
            current_ok_next = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control, configuration and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid          <= 1'b0;
      out_valid         <= 1'b0;
      blanking_ticks    <= BLANKING_TICKS_RST;
      rise_threshold_mv <= RISE_THRESHOLD_RST;
      current_low_mv    <= CURRENT_LOW_RST;
      current_high_mv   <= CURRENT_HIGH_RST;
      last_voltage      <= '0;
      blanking_active   <= 1'b0;
      elapsed_ticks     <= '0;
      held_duty_a       <= '0;
      held_duty_b       <= '0;
      held_low_a        <= 1'b0;
      held_low_b        <= 1'b1;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_BLANKING_TICKS: blanking_ticks    <= wr_data[TICK_W-1:0];
          REG_RISE_THRESHOLD: rise_threshold_mv <= wr_data[VOLT_W-1:0];
          REG_CURRENT_LOW:    current_low_mv    <= wr_data[CUR_W-1:0];
          REG_CURRENT_HIGH:   current_high_mv   <= wr_data[CUR_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.ready) begin
        s0_valid <= cmd.valid;
      end
      if (advance) begin
        out_valid       <= 1'b1;
        last_voltage    <= last_voltage_next;
        blanking_active <= blanking_active_next;
        elapsed_ticks   <= elapsed_ticks_next;
        held_duty_a     <= held_duty_a_next;
        held_duty_b     <= held_duty_b_next;
        held_low_a      <= held_low_a_next;
        held_low_b      <= held_low_b_next;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s0_action    <= cmd.action;
      s0_voltage   <= cmd.voltage_mv;
      s0_direction <= cmd.direction;
      s0_current   <= cmd.current_mv;
    end
    if (advance) begin
      current_ok <= current_ok_next;
    end
  end

  // Held bridge state doubles as the result payload
  assign res.valid      = out_valid;
  assign res.duty_a     = held_duty_a;
  assign res.duty_b     = held_duty_b;
  assign res.low_a_on   = held_low_a;
  assign res.low_b_on   = held_low_b;
  assign res.current_ok = current_ok;

endmodule

// ===== sv/hbsb_checker.sv =====
// hbsb_checker: port-level assertions for the H-bridge surge blanking block,
// bound to the top level. Depends on hbsb_pkg.
module hbsb_checker import hbsb_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              res_valid,
  input logic              res_ready,
  input logic [DUTY_W-1:0] res_duty_a,
  input logic [DUTY_W-1:0] res_duty_b,
  input logic              res_low_a_on,
  input logic              res_low_b_on,
  input logic              res_current_ok
);

  // No result word right after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

  // A stalled result word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_duty_a) && $stable(res_duty_b)
      && $stable(res_low_a_on) && $stable(res_low_b_on) && $stable(res_current_ok))
    else $error("stalled result word changed");

  // Exactly one low switch is on
  a_one_low: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_low_a_on != res_low_b_on))
    else $error("low switches not complementary");

  // The side whose low switch is on has its high switch off
  a_no_shoot: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_low_a_on ? (res_duty_a == '0) : (res_duty_b == '0)))
    else $error("high and low switch on in the same leg");

  // Duty never exceeds the PWM period
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_duty_a <= PWM_PERIOD) && (res_duty_b <= PWM_PERIOD))
    else $error("duty above PWM period");

endmodule

bind hbridge_drive_surge_blanking hbsb_checker u_hbsb_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .res_duty_a     (res.duty_a),
  .res_duty_b     (res.duty_b),
  .res_low_a_on   (res.low_a_on),
  .res_low_b_on   (res.low_b_on),
  .res_current_ok (res.current_ok)
);
